// ----- sv/rolling_mean_stddev_defines.svh -----
// Assertion macros shared by the rolling mean and deviation RTL
`ifndef ROLLING_MEAN_STDDEV_DEFINES_SVH
`define ROLLING_MEAN_STDDEV_DEFINES_SVH
// assert an implication on every clock edge outside reset
`define RMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// assert an implication in the next cycle
`define RMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- sv/rms_pkg.sv -----
// Package: types and constants for the rolling mean and deviation block
`default_nettype none
package rms_pkg;
  localparam int unsigned CfgIdxWindow = 0;
  localparam int unsigned CfgIdxMode   = 1;
  localparam int unsigned CfgIdxBits   = 1;
  localparam int unsigned CfgDataBits  = 7;
  localparam int unsigned SumBits      = 31;
  localparam int unsigned SqBits       = 54;
  localparam int unsigned InBits       = 24;
  localparam int unsigned StdBits      = 23;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RDOLD, ST_UPD, ST_PREP, ST_DIV, ST_SQRT, ST_OUT, ST_DONE
  } state_t;

  // control from the sequencer to the arithmetic unit
  typedef struct packed {
    logic start;
    logic [6:0] divisor;
  } math_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } math_sts_t;
endpackage
`default_nettype wire

// ----- sv/rms_if.sv -----
// Interfaces: sample, result and configuration request channels
`default_nettype none
interface rms_in_if;
  logic valid;
  logic ready;
  logic [23:0] sample_value;
  logic last_sample;
  modport source (output valid, sample_value, last_sample, input ready);
  modport sink (input valid, sample_value, last_sample, output ready);
endinterface

interface rms_out_if;
  logic valid;
  logic ready;
  logic [23:0] window_mean;
  logic [22:0] window_std;
  logic last_result;
  modport source (output valid, window_mean, window_std, last_result, input ready);
  modport sink (input valid, window_mean, window_std, last_result, output ready);
endinterface

interface rms_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/rms_math.sv -----
// Bit-serial divider and square root: mean, mean of squares, deviation
`default_nettype none
module rms_math #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire rms_pkg::math_ctl_t ctl,
  input  wire logic signed [rms_pkg::SumBits-1:0] sum_in,
  input  wire logic [rms_pkg::SqBits-1:0] sq_in,
  output rms_pkg::math_sts_t sts,
  output logic signed [rms_pkg::InBits-1:0] mean_out,
  output logic [rms_pkg::StdBits-1:0] std_out
);
  localparam int unsigned SB = rms_pkg::SumBits;
  localparam int unsigned QB = rms_pkg::SqBits;
  localparam int unsigned CB = 6;
  localparam logic signed [47:0] MaxV = (48'sd1 <<< (SAMPLE_BITS - 1)) - 48'sd1;
  localparam logic signed [47:0] MinV = -(48'sd1 <<< (SAMPLE_BITS - 1));

  typedef enum logic [2:0] {M_IDLE, M_DIV, M_MUL, M_SQRT, M_FIN} mst_t;

  mst_t st_r, st_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic [6:0] d_r;
  logic neg_r;
  // dividend shift registers; quotient bits enter at the bottom
  logic [SB-1:0] qs_r;
  logic [7:0] rs_r;
  logic [QB-1:0] qq_r;
  logic [7:0] rq_r;
  logic [47:0] msq_r;
  logic [53:0] var_r;
  logic [26:0] root_r;
  logic [28:0] srem_r;
  logic [47:0] sqmean_r;
  logic signed [47:0] meanv_r;
  logic done_r;
  logic [8:0] ts, tq;
  logic [28:0] trial;

  assign sts.busy = (st_r != M_IDLE);
  assign sts.done = done_r;

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    case (st_r)
      M_IDLE: if (ctl.start) begin st_nxt = M_DIV; cnt_nxt = '0; end
      M_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CB'(QB - 1)) begin st_nxt = M_MUL; cnt_nxt = '0; end
      end
      M_MUL: begin st_nxt = M_SQRT; cnt_nxt = '0; end
      M_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CB'(27)) st_nxt = M_FIN;
      end
      M_FIN: st_nxt = M_IDLE;
      default: st_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= M_IDLE;
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      done_r <= (st_r == M_FIN);
    end
  end

  // one restoring step per cycle for both quotients
  always_comb begin
    ts = {rs_r, qs_r[SB-1]};
    tq = {rq_r, qq_r[QB-1]};
    trial = srem_r - {root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    case (st_r)
      M_IDLE: if (ctl.start) begin
        d_r <= (ctl.divisor == '0) ? 7'd1 : ctl.divisor;
        neg_r <= sum_in[SB-1];
        qs_r <= sum_in[SB-1] ? SB'(-sum_in) : sum_in;
        rs_r <= '0;
        qq_r <= sq_in;
        rq_r <= '0;
      end
      M_DIV: begin
        if (cnt_r < CB'(SB)) begin
          if (ts >= {2'b0, d_r}) begin
            rs_r <= 8'(ts - {2'b0, d_r}); qs_r <= {qs_r[SB-2:0], 1'b1};
          end else begin
            rs_r <= ts[7:0]; qs_r <= {qs_r[SB-2:0], 1'b0};
          end
        end
        if (tq >= {2'b0, d_r}) begin
          rq_r <= 8'(tq - {2'b0, d_r}); qq_r <= {qq_r[QB-2:0], 1'b1};
        end else begin
          rq_r <= tq[7:0]; qq_r <= {qq_r[QB-2:0], 1'b0};
        end
      end
      M_MUL: begin
        meanv_r <= neg_r ? -48'(signed'({1'b0, qs_r})) : 48'(signed'({1'b0, qs_r}));
        // |mean| <= 2^23, square fits 47 bits; msq < 2^48
        sqmean_r <= 48'(qs_r[23:0]) * 48'(qs_r[23:0]);
        msq_r <= qq_r[47:0];
        root_r <= '0;
        srem_r <= '0;
      end
      M_SQRT: begin
        if (cnt_r == '0) begin
          // top pair goes to the remainder now; keep the next pair on top
          var_r <= (msq_r > sqmean_r) ? (54'(msq_r - sqmean_r) << 2) : '0;
        end else begin
          var_r <= {var_r[51:0], 2'b00};
        end
      end
      default: ;
    endcase
    // root digit recurrence, one bit per cycle after the variance is set
    if (st_r == M_SQRT && cnt_r != '0) begin
      if (!trial[28]) begin
        srem_r <= {trial[26:0], var_r[53:52]};
        root_r <= {root_r[25:0], 1'b1};
      end else begin
        srem_r <= {srem_r[26:0], var_r[53:52]};
        root_r <= {root_r[25:0], 1'b0};
      end
    end else if (st_r == M_SQRT) begin
      srem_r <= 29'(((msq_r > sqmean_r) ? 54'(msq_r - sqmean_r) : 54'd0) >> 52);
    end
    if (st_r == M_FIN) begin
      if (meanv_r > MaxV) mean_out <= MaxV[23:0];
      else if (meanv_r < MinV) mean_out <= MinV[23:0];
      else mean_out <= meanv_r[23:0];
      if ({21'b0, root_r} > MaxV) std_out <= MaxV[22:0];
      else std_out <= root_r[22:0];
    end
  end
endmodule
`default_nettype wire

// ----- sv/rolling_mean_stddev.sv -----
// Top level: rolling window history, running sums, sequencer and result register
// A sample giving a result runs read, update, prep, a 54-step divide, the square root
// and the output handoff before result valid.
// A sample giving no result skips the math; centered flush adds one pass per padding zero.
// Series end and config writes add a clearing pass over all MAX_WINDOW history slots (64 by default).
// Reset runs the clearing pass and sets window_length to 20, trailing_mode to 1.
`default_nettype none
`include "rolling_mean_stddev_defines.svh"
module rolling_mean_stddev #(
  parameter int unsigned MAX_WINDOW = 64,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input wire logic clk,
  input wire logic rst_n,
  rms_in_if.sink in_ch,
  rms_out_if.source out_ch,
  rms_cfg_if.sink cfg_ch
);
  localparam int unsigned AW = $clog2(MAX_WINDOW);
  localparam int unsigned SB = rms_pkg::SumBits;
  localparam int unsigned QB = rms_pkg::SqBits;

  rms_pkg::state_t st_r, st_nxt;
  logic [6:0] win_r;
  logic mode_r;
  logic signed [rms_pkg::InBits-1:0] hist [MAX_WINDOW];
  logic signed [rms_pkg::InBits-1:0] old_r;
  logic [AW-1:0] ptr_r, clr_r;
  logic [AW-1:0] old_idx;
  logic [6:0] seen_r, flush_r;
  logic signed [SB-1:0] sum_r;
  logic [QB-1:0] sq_r;
  logic signed [rms_pkg::InBits-1:0] x_r;
  logic last_r;
  logic ov_r;
  logic [23:0] om_r;
  logic [22:0] os_r;
  logic ol_r;
  logic [6:0] w_eff, pad;
  rms_pkg::math_ctl_t mctl;
  rms_pkg::math_sts_t msts;
  logic signed [23:0] m_mean;
  logic [22:0] m_std;
  logic signed [47:0] xsq, osq;
  logic emit_now;
  logic flushing;

  assign w_eff = (win_r == '0) ? 7'd1 : (win_r > 7'(MAX_WINDOW)) ? 7'(MAX_WINDOW) : win_r;
  assign pad = (w_eff - 7'd1) >> 1;
  assign flushing = (flush_r != '0);

  // slot leaving the window, wrapped around the history depth
  assign old_idx = (7'(ptr_r) >= w_eff) ? AW'(7'(ptr_r) - w_eff) :
                   AW'(7'(ptr_r) + 7'(MAX_WINDOW) - w_eff);

  assign in_ch.ready = (st_r == rms_pkg::ST_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (st_r == rms_pkg::ST_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.window_mean = om_r;
  assign out_ch.window_std = os_r;
  assign out_ch.last_result = ol_r;

  // emit after update when this sample yields a result
  assign emit_now = mode_r || (seen_r > pad);
  assign mctl.start = (st_r == rms_pkg::ST_PREP) && emit_now;
  assign mctl.divisor = mode_r ? seen_r : w_eff;

  rms_math #(.SAMPLE_BITS(SAMPLE_BITS)) u_math (
    .clk(clk), .rst_n(rst_n), .ctl(mctl), .sum_in(sum_r), .sq_in(sq_r),
    .sts(msts), .mean_out(m_mean), .std_out(m_std)
  );

  always_comb begin
    xsq = 48'(x_r) * 48'(x_r);
    osq = 48'(old_r) * 48'(old_r);
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rms_pkg::ST_CLEAR: if (clr_r == AW'(MAX_WINDOW - 1)) st_nxt = rms_pkg::ST_IDLE;
      rms_pkg::ST_IDLE: begin
        if (cfg_ch.valid && cfg_ch.ready) st_nxt = rms_pkg::ST_CLEAR;
        else if (in_ch.valid && in_ch.ready) st_nxt = rms_pkg::ST_RDOLD;
      end
      rms_pkg::ST_RDOLD: st_nxt = rms_pkg::ST_UPD;
      rms_pkg::ST_UPD: st_nxt = rms_pkg::ST_PREP;
      rms_pkg::ST_PREP: st_nxt = emit_now ? rms_pkg::ST_DIV : rms_pkg::ST_DONE;
      rms_pkg::ST_DIV: if (msts.done) st_nxt = rms_pkg::ST_OUT;
      rms_pkg::ST_OUT: if (!ov_r) st_nxt = rms_pkg::ST_DONE;
      rms_pkg::ST_DONE: begin
        if (last_r && !mode_r && flushing) st_nxt = rms_pkg::ST_RDOLD;
        else if (last_r) st_nxt = rms_pkg::ST_CLEAR;
        else st_nxt = rms_pkg::ST_IDLE;
      end
      default: st_nxt = rms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rms_pkg::ST_CLEAR;
      win_r <= 7'd20;
      mode_r <= 1'b1;
      clr_r <= '0;
      ptr_r <= '0;
      seen_r <= '0;
      sum_r <= '0;
      sq_r <= '0;
      ov_r <= 1'b0;
      flush_r <= '0;
      last_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      case (st_r)
        rms_pkg::ST_CLEAR: begin
          clr_r <= (clr_r == AW'(MAX_WINDOW - 1)) ? '0 : clr_r + 1'b1;
          ptr_r <= '0; seen_r <= '0; sum_r <= '0; sq_r <= '0;
          flush_r <= '0; last_r <= 1'b0;
        end
        rms_pkg::ST_IDLE: begin
          if (cfg_ch.valid && cfg_ch.ready) begin
            clr_r <= '0;
            if (cfg_ch.index == 1'(rms_pkg::CfgIdxWindow)) win_r <= cfg_ch.data;
            else mode_r <= cfg_ch.data[0];
          end else if (in_ch.valid && in_ch.ready) begin
            last_r <= in_ch.last_sample;
            flush_r <= in_ch.last_sample ? pad : '0;
          end
        end
        rms_pkg::ST_UPD: begin
          if (seen_r >= w_eff) begin
            sum_r <= sum_r + SB'(x_r) - SB'(old_r);
            sq_r <= sq_r + QB'(xsq) - QB'(osq);
          end else begin
            sum_r <= sum_r + SB'(x_r);
            sq_r <= sq_r + QB'(xsq);
            seen_r <= seen_r + 1'b1;
          end
          ptr_r <= (ptr_r == AW'(MAX_WINDOW - 1)) ? '0 : ptr_r + 1'b1;
        end
        rms_pkg::ST_OUT: if (!ov_r) begin
          ov_r <= 1'b1;
        end
        rms_pkg::ST_DONE: if (last_r && !mode_r && flushing) flush_r <= flush_r - 1'b1;
        default: ;
      endcase
    end
  end

  // history memory and payload registers
  always_ff @(posedge clk) begin
    if (st_r == rms_pkg::ST_CLEAR) hist[clr_r] <= '0;
    if (st_r == rms_pkg::ST_IDLE && in_ch.valid && in_ch.ready)
      x_r <= 24'(signed'(in_ch.sample_value[SAMPLE_BITS-1:0]));
    if (st_r == rms_pkg::ST_DONE) x_r <= '0;
    if (st_r == rms_pkg::ST_RDOLD) old_r <= hist[old_idx];
    if (st_r == rms_pkg::ST_UPD) hist[ptr_r] <= x_r;
    if (st_r == rms_pkg::ST_OUT && !ov_r) begin
      om_r <= m_mean;
      os_r <= m_std;
      ol_r <= last_r && (mode_r || flush_r == '0);
    end
  end

  `RMS_ASSERT_NXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped")
  `RMS_ASSERT_IMP(a_no_in_busy, clk, rst_n, st_r != rms_pkg::ST_IDLE, !in_ch.ready, "request taken while busy")
  `RMS_ASSERT_IMP(a_seen_bound, clk, rst_n, 1'b1, seen_r <= 7'(MAX_WINDOW), "count overflow")
  `RMS_ASSERT_IMP(a_math_busy, clk, rst_n, st_r == rms_pkg::ST_DIV, msts.busy || msts.done, "math unit idle while awaited")
endmodule
`default_nettype wire
